// ===== hdl/assert_macros.svh =====
// concurrent assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FCL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcl assertion failed");

// next-cycle implication
`define FCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcl assertion failed");

`endif

// ===== hdl/fcl_pkg.sv =====
`timescale 1ns / 1ps
package fcl_pkg;

    localparam int NONE_CODE_DEF   = 255;
    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int LOD_SHIFT    = 34;
    localparam int OFFSET_SHIFT = 16;
    localparam int CFG_IDX_W    = 3;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic [1:0] COMP_OFFSET = 2'd3;

    localparam logic [31:0] EYE_RST            = 32'd0;
    localparam logic [31:0] LOD_SCALE_RST      = 32'd65536;
    localparam logic [7:0]  OUTSIDE_LEVELS_RST = 8'd2;
    localparam logic [7:0]  MAX_DEPTH_RST      = 8'd254;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EYE_X          = 3'd0,
        CFG_EYE_Y          = 3'd1,
        CFG_EYE_Z          = 3'd2,
        CFG_LOD_SCALE      = 3'd3,
        CFG_OUTSIDE_LEVELS = 3'd4,
        CFG_MAX_DEPTH      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               command;
        logic [4:0]         coef_index;
        logic signed [31:0] coef_value;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic [7:0]         depth;
    } t_request;

    typedef struct packed {
        logic [7:0] mark_level;
        logic       is_outside;
    } t_result;

    typedef struct packed {
        logic               valid;
        logic               command;
        logic [4:0]         coef_index;
        logic signed [31:0] coef_value;
        logic [7:0]         depth;
        logic               too_deep;
        logic               outside;
    } t_chain_tag;

    typedef struct packed {
        logic       valid;
        logic [7:0] depth;
        logic       too_deep;
        logic       outside;
        logic       lhs_zero;
        logic       rhs_zero;
    } t_lod_tag;

endpackage

// ===== hdl/fcl_plane_cell.sv =====
`timescale 1ns / 1ps
module fcl_plane_cell #(
    parameter int CW = fcl_pkg::COORD_WIDTH_DEF,
    parameter int ID = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fcl_pkg::t_chain_tag  i_tag,
    input  logic signed [CW-1:0] i_lo [3],
    input  logic signed [CW-1:0] i_hi [3],
    output fcl_pkg::t_chain_tag  o_tag,
    output logic signed [CW-1:0] o_lo [3],
    output logic signed [CW-1:0] o_hi [3]
);
    localparam int PW = 32 + CW;
    localparam int SW = CW + 34;
    localparam int OW = 32 + fcl_pkg::OFFSET_SHIFT;

    logic signed [31:0]   r_coef [4];
    logic signed [PW-1:0] n_prod [3];
    logic signed [PW-1:0] r_prod [3];
    logic signed [OW-1:0] r_off;
    logic signed [SW-1:0] n_sum;
    logic                 n_hit;
    fcl_pkg::t_chain_tag  r_tag_a, r_tag_b, n_tag_b;
    logic signed [CW-1:0] r_lo_a [3], r_hi_a [3], r_lo_b [3], r_hi_b [3];

    // far corner per axis, then coefficient times corner
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_prod[c] = r_coef[c] * ((r_coef[c] > 0) ? i_hi[c] : i_lo[c]);
        end
        n_hit = i_tag.valid && (i_tag.command == fcl_pkg::CMD_LOAD)
                && (i_tag.coef_index[4:2] == 3'(ID));
    end

    always_ff @(posedge i_clk) begin
        if (n_hit) begin
            r_coef[i_tag.coef_index[1:0]] <= i_tag.coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a.valid <= 1'b0;
        end else begin
            r_tag_a <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_a <= i_lo;
        r_hi_a <= i_hi;
        r_prod <= n_prod;
        r_off  <= $signed({r_coef[fcl_pkg::COMP_OFFSET], fcl_pkg::OFFSET_SHIFT'(0)});
    end

    // signed distance of the far corner
    always_comb begin
        n_sum = SW'(r_prod[0]) + SW'(r_prod[1]) + SW'(r_prod[2]) + SW'(r_off);
        n_tag_b = r_tag_a;
        n_tag_b.outside = r_tag_a.outside
                          | ((r_tag_a.command == fcl_pkg::CMD_CLASSIFY) & n_sum[SW-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_b.valid <= 1'b0;
        end else begin
            r_tag_b <= n_tag_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_b <= r_lo_a;
        r_hi_b <= r_hi_a;
    end

    assign o_tag = r_tag_b;
    assign o_lo  = r_lo_b;
    assign o_hi  = r_hi_b;

endmodule

// ===== hdl/fcl_search_cell.sv =====
`timescale 1ns / 1ps
module fcl_search_cell #(
    parameter int LW  = 102,
    parameter int RW  = 134,
    parameter int NB  = 6,
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcl_pkg::t_lod_tag i_tag,
    input  logic [NB-1:0]     i_n,
    input  logic [LW-1:0]     i_lhs,
    input  logic [RW-1:0]     i_rhs,
    output fcl_pkg::t_lod_tag o_tag,
    output logic [NB-1:0]     o_n,
    output logic [LW-1:0]     o_lhs,
    output logic [RW-1:0]     o_rhs
);
    localparam int XW = (LW > RW) ? LW : RW;

    logic [NB-1:0]     n_try, n_n, r_n;
    logic [NB:0]       n_sh;
    logic              n_fail;
    fcl_pkg::t_lod_tag r_tag;
    logic [LW-1:0]     r_lhs;
    logic [RW-1:0]     r_rhs;

    // test n + 2^bit - 1: lhs >= rhs * 4^n means this bit is needed
    always_comb begin
        n_try  = i_n | NB'((1 << BIT) - 1);
        n_sh   = {n_try, 1'b0};
        n_fail = !i_tag.lhs_zero && ((XW'(i_lhs) >> n_sh) >= XW'(i_rhs));
        n_n    = n_fail ? (i_n | NB'(1 << BIT)) : i_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_lhs <= i_lhs;
        r_rhs <= i_rhs;
    end

    assign o_tag = r_tag;
    assign o_n   = r_n;
    assign o_lhs = r_lhs;
    assign o_rhs = r_rhs;

endmodule

// ===== hdl/frustum_cull_lod_marker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// channel   | ports                              | handshake
// ----------+------------------------------------+-------------------------------
// request   | i_start, i_req, o_busy             | taken when i_start and !o_busy
// result    | o_valid, o_result                  | one-cycle strobe, no back-pressure
// config    | i_cfg_we, i_cfg_idx, i_cfg_data    | written when i_cfg_we
//
// one request per cycle; o_busy stays low
// the pipeline has one input stage, two per plane cell,
// seven for squares and the scale products, one per search bit, one output stage
// load requests flow through the plane cells in order and give no result
// synchronous active-low reset clears pipeline valids and sets the config registers to their defaults
module frustum_cull_lod_marker #(
    parameter int NONE_CODE   = fcl_pkg::NONE_CODE_DEF,
    parameter int PLANE_COUNT = fcl_pkg::PLANE_COUNT_DEF,
    parameter int COORD_WIDTH = fcl_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  fcl_pkg::t_request               i_req,
    output logic                            o_busy,
    input  logic                            i_cfg_we,
    input  logic [fcl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    output logic                            o_valid,
    output fcl_pkg::t_result                o_result
);
    localparam int CW      = COORD_WIDTH;
    localparam int DW      = 2 * (CW + 1) + 2;
    localparam int EW      = 2 * (CW + 2) + 2;
    localparam int LW      = DW + fcl_pkg::LOD_SHIFT;
    localparam int H       = EW / 2;
    localparam int MW      = 32 + EW;
    localparam int K       = (MW + 2) / 3;
    localparam int RW      = 64 + EW;
    localparam int NB      = $clog2(LW / 2 + 2);
    localparam int XW      = (LW > RW) ? LW : RW;
    localparam int LATENCY = 2 * PLANE_COUNT + NB + 9;

    // config registers
    logic [31:0] r_eye [3];
    logic [31:0] r_lod_scale;
    logic [7:0]  r_outside_levels;
    logic [7:0]  r_max_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye[0]         <= fcl_pkg::EYE_RST;
            r_eye[1]         <= fcl_pkg::EYE_RST;
            r_eye[2]         <= fcl_pkg::EYE_RST;
            r_lod_scale      <= fcl_pkg::LOD_SCALE_RST;
            r_outside_levels <= fcl_pkg::OUTSIDE_LEVELS_RST;
            r_max_depth      <= fcl_pkg::MAX_DEPTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fcl_pkg::CFG_EYE_X:          r_eye[0] <= i_cfg_data;
                fcl_pkg::CFG_EYE_Y:          r_eye[1] <= i_cfg_data;
                fcl_pkg::CFG_EYE_Z:          r_eye[2] <= i_cfg_data;
                fcl_pkg::CFG_LOD_SCALE:      r_lod_scale <= i_cfg_data;
                fcl_pkg::CFG_OUTSIDE_LEVELS: r_outside_levels <= i_cfg_data[7:0];
                fcl_pkg::CFG_MAX_DEPTH:      r_max_depth <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_busy = 1'b0;

    // input stage
    fcl_pkg::t_chain_tag  w_ctag [PLANE_COUNT+1];
    logic signed [CW-1:0] w_clo  [PLANE_COUNT+1][3];
    logic signed [CW-1:0] w_chi  [PLANE_COUNT+1][3];
    fcl_pkg::t_chain_tag  r_s0, n_s0;
    logic signed [CW-1:0] r_s0_lo [3], r_s0_hi [3];

    always_comb begin
        n_s0.valid      = i_start && !o_busy;
        n_s0.command    = i_req.command;
        n_s0.coef_index = i_req.coef_index;
        n_s0.coef_value = i_req.coef_value;
        n_s0.depth      = i_req.depth;
        n_s0.too_deep   = i_req.depth > r_max_depth;
        n_s0.outside    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else begin
            r_s0 <= n_s0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_lo[0] <= CW'($unsigned(i_req.box_min_x));
        r_s0_lo[1] <= CW'($unsigned(i_req.box_min_y));
        r_s0_lo[2] <= CW'($unsigned(i_req.box_min_z));
        r_s0_hi[0] <= CW'($unsigned(i_req.box_max_x));
        r_s0_hi[1] <= CW'($unsigned(i_req.box_max_y));
        r_s0_hi[2] <= CW'($unsigned(i_req.box_max_z));
    end

    assign w_ctag[0] = r_s0;
    assign w_clo[0]  = r_s0_lo;
    assign w_chi[0]  = r_s0_hi;

    // plane cells
    for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_plane
        fcl_plane_cell #(
            .CW (CW),
            .ID (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (w_ctag[k]),
            .i_lo    (w_clo[k]),
            .i_hi    (w_chi[k]),
            .o_tag   (w_ctag[k+1]),
            .o_lo    (w_clo[k+1]),
            .o_hi    (w_chi[k+1])
        );
    end

    // box extent and twice the centre offset from the eye, as magnitudes
    logic signed [CW-1:0]   n_eye [3];
    logic signed [CW:0]     n_d [3];
    logic signed [CW+1:0]   n_e [3];
    logic [CW:0]            n_dmag [3], r_dmag [3];
    logic [CW+1:0]          n_emag [3], r_emag [3];
    fcl_pkg::t_lod_tag      n_t1, r_t1, r_t2, r_t3, r_t4, r_t5, n_t5, r_t6, r_t7, n_t7;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_eye[c]  = CW'(r_eye[c]);
            n_d[c]    = (CW+1)'(w_chi[PLANE_COUNT][c]) - (CW+1)'(w_clo[PLANE_COUNT][c]);
            n_e[c]    = (CW+2)'(w_clo[PLANE_COUNT][c]) + (CW+2)'(w_chi[PLANE_COUNT][c])
                        - ((CW+2)'(n_eye[c]) <<< 1);
            n_dmag[c] = n_d[c][CW] ? (CW+1)'(-n_d[c]) : (CW+1)'(n_d[c]);
            n_emag[c] = n_e[c][CW+1] ? (CW+2)'(-n_e[c]) : (CW+2)'(n_e[c]);
        end
        n_t1.valid    = w_ctag[PLANE_COUNT].valid
                        && (w_ctag[PLANE_COUNT].command == fcl_pkg::CMD_CLASSIFY);
        n_t1.depth    = w_ctag[PLANE_COUNT].depth;
        n_t1.too_deep = w_ctag[PLANE_COUNT].too_deep;
        n_t1.outside  = w_ctag[PLANE_COUNT].outside;
        n_t1.lhs_zero = 1'b0;
        n_t1.rhs_zero = 1'b0;
    end

    // squares, sums, then scale^2 * dist4 as partial products
    logic [2*CW+1:0]         r_dd [3];
    logic [2*CW+3:0]         r_ee [3];
    logic [DW-1:0]           r_diam2, r_diam2_4;
    logic [EW-1:0]           r_dist4;
    logic [32+H-1:0]         r_plo;
    logic [32+EW-H-1:0]      r_phi;
    logic [MW-1:0]           r_mid;
    logic [LW-1:0]           r_lhs5, r_lhs6, r_lhs7;
    logic [32+K-1:0]         r_q0, r_q1;
    logic [32+MW-2*K-1:0]    r_q2;
    logic [RW-1:0]           r_rhs, n_rhs;

    always_comb begin
        n_t5 = r_t4;
        n_t5.lhs_zero = (r_diam2_4 == '0);
        n_rhs = RW'(r_q0) + (RW'(r_q1) << K) + (RW'(r_q2) << (2 * K));
        n_t7 = r_t6;
        n_t7.rhs_zero = (n_rhs == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.valid <= 1'b0;
            r_t2.valid <= 1'b0;
            r_t3.valid <= 1'b0;
            r_t4.valid <= 1'b0;
            r_t5.valid <= 1'b0;
            r_t6.valid <= 1'b0;
            r_t7.valid <= 1'b0;
        end else begin
            r_t1 <= n_t1;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
            r_t4 <= r_t3;
            r_t5 <= n_t5;
            r_t6 <= r_t5;
            r_t7 <= n_t7;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dmag <= n_dmag;
        r_emag <= n_emag;
        for (int c = 0; c < 3; c++) begin
            r_dd[c] <= r_dmag[c] * r_dmag[c];
            r_ee[c] <= r_emag[c] * r_emag[c];
        end
        r_diam2   <= DW'(r_dd[0]) + DW'(r_dd[1]) + DW'(r_dd[2]);
        r_dist4   <= EW'(r_ee[0]) + EW'(r_ee[1]) + EW'(r_ee[2]);
        r_plo     <= r_lod_scale * r_dist4[H-1:0];
        r_phi     <= r_lod_scale * r_dist4[EW-1:H];
        r_diam2_4 <= r_diam2;
        r_mid     <= MW'(r_plo) + (MW'(r_phi) << H);
        r_lhs5    <= {r_diam2_4, fcl_pkg::LOD_SHIFT'(0)} - LW'(1);
        r_q0      <= r_lod_scale * r_mid[K-1:0];
        r_q1      <= r_lod_scale * r_mid[2*K-1:K];
        r_q2      <= r_lod_scale * r_mid[MW-1:2*K];
        r_lhs6    <= r_lhs5;
        r_rhs     <= n_rhs;
        r_lhs7    <= r_lhs6;
    end

    // search cells, most significant bit of n first
    fcl_pkg::t_lod_tag w_stag [NB+1];
    logic [NB-1:0]     w_sn   [NB+1];
    logic [LW-1:0]     w_slhs [NB+1];
    logic [RW-1:0]     w_srhs [NB+1];

    assign w_stag[0] = r_t7;
    assign w_sn[0]   = '0;
    assign w_slhs[0] = r_lhs7;
    assign w_srhs[0] = r_rhs;

    for (genvar g = 0; g < NB; g++) begin : g_search
        fcl_search_cell #(
            .LW  (LW),
            .RW  (RW),
            .NB  (NB),
            .BIT (NB - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (w_stag[g]),
            .i_n     (w_sn[g]),
            .i_lhs   (w_slhs[g]),
            .i_rhs   (w_srhs[g]),
            .o_tag   (w_stag[g+1]),
            .o_n     (w_sn[g+1]),
            .o_lhs   (w_slhs[g+1]),
            .o_rhs   (w_srhs[g+1])
        );
    end

    // mark selection and saturation
    fcl_pkg::t_result n_result, r_result;
    logic             r_out_valid;
    logic [8:0]       n_lod_sum, n_out_sum, n_cap;

    always_comb begin
        n_cap     = 9'(NONE_CODE - 1);
        n_lod_sum = 9'(w_stag[NB].depth) + 9'(w_sn[NB]);
        n_out_sum = 9'(w_stag[NB].depth) + 9'(r_outside_levels);
        n_result.is_outside = 1'b0;
        if (w_stag[NB].too_deep) begin
            n_result.mark_level = 8'(NONE_CODE);
        end else if (w_stag[NB].outside) begin
            n_result.is_outside = 1'b1;
            n_result.mark_level = (n_out_sum > n_cap) ? n_cap[7:0] : n_out_sum[7:0];
        end else if (w_stag[NB].rhs_zero) begin
            n_result.mark_level = 8'(NONE_CODE);
        end else begin
            n_result.mark_level = (n_lod_sum > n_cap) ? n_cap[7:0] : n_lod_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_stag[NB].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    `FCL_ASSERT_IMPL(a_result_has_request, i_clk, i_rst_n, o_valid,
        $past(i_start && (i_req.command == fcl_pkg::CMD_CLASSIFY), LATENCY))
    `FCL_ASSERT_IMPL(a_outside_is_marked, i_clk, i_rst_n, o_valid && o_result.is_outside,
        o_result.mark_level != 8'(NONE_CODE))
    `FCL_ASSERT_IMPL(a_search_settles, i_clk, i_rst_n,
        w_stag[NB].valid && !w_stag[NB].lhs_zero && !w_stag[NB].rhs_zero,
        (XW'(w_slhs[NB]) >> {w_sn[NB], 1'b0}) < XW'(w_srhs[NB]))
    `FCL_ASSERT_NEXT(a_load_no_lod, i_clk, i_rst_n,
        w_ctag[PLANE_COUNT].valid && (w_ctag[PLANE_COUNT].command == fcl_pkg::CMD_LOAD),
        !r_t1.valid)

endmodule

// ===== dv/tb_frustum_cull_lod_marker.sv =====
`timescale 1ns / 1ps
module tb_frustum_cull_lod_marker;

    localparam int DRAIN_CYCLES = 80;
    localparam int SLOTS = 4 * fcl_pkg::PLANE_COUNT_DEF;
    localparam logic [7:0] NONE = 8'(fcl_pkg::NONE_CODE_DEF);
    localparam logic [7:0] TOP = 8'(fcl_pkg::NONE_CODE_DEF - 1);

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_start;
    fcl_pkg::t_request             i_req;
    logic                          o_busy;
    logic                          i_cfg_we;
    logic [fcl_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]                   i_cfg_data;
    logic                          o_valid;
    fcl_pkg::t_result              o_result;

    frustum_cull_lod_marker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .o_busy(o_busy), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_result(o_result)
    );

    // predictor state
    logic signed [31:0] plane_coef [SLOTS];
    logic signed [31:0] eye [3];
    logic [31:0]        scale;
    logic [7:0]         out_levels;
    logic [7:0]         depth_limit;

    fcl_pkg::t_result pending_marks[$];
    int               err_count;
    int               idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb_frustum_cull_lod_marker: done, errors");
        $finish;
    end

    function automatic fcl_pkg::t_result mark_node(fcl_pkg::t_request r);
        fcl_pkg::t_result    res;
        logic signed [31:0]  lo [3];
        logic signed [31:0]  hi [3];
        logic signed [127:0] acc, term, dt, et;
        logic [255:0]        diam2, dist4, lhs, rhs;
        logic [8:0]          sum;
        int                  n;
        bit                  outside;
        lo[0] = r.box_min_x; lo[1] = r.box_min_y; lo[2] = r.box_min_z;
        hi[0] = r.box_max_x; hi[1] = r.box_max_y; hi[2] = r.box_max_z;
        res = '0;
        if (r.depth > depth_limit) begin
            res.mark_level = NONE;
            return res;
        end
        outside = 0;
        for (int k = 0; k < fcl_pkg::PLANE_COUNT_DEF; k++) begin
            acc = 128'(plane_coef[4*k+3]) <<< 16;
            for (int c = 0; c < 3; c++) begin
                term = 128'(plane_coef[4*k+c]);
                dt = (plane_coef[4*k+c] > 0) ? 128'(hi[c]) : 128'(lo[c]);
                acc = acc + term * dt;
            end
            if (acc < 0) outside = 1;
        end
        res.is_outside = outside;
        if (outside) begin
            sum = 9'(r.depth) + 9'(out_levels);
            res.mark_level = (sum > 9'(TOP)) ? TOP : sum[7:0];
            return res;
        end
        diam2 = '0;
        dist4 = '0;
        for (int c = 0; c < 3; c++) begin
            dt = 128'(hi[c]) - 128'(lo[c]);
            et = 128'(lo[c]) + 128'(hi[c]) - (128'(eye[c]) <<< 1);
            term = dt * dt;
            diam2 = diam2 + 256'(term);
            term = et * et;
            dist4 = dist4 + 256'(term);
        end
        if (scale == 0 || dist4 == 0) begin
            res.mark_level = NONE;
            return res;
        end
        lhs = diam2 << 34;
        rhs = 256'(scale) * 256'(scale) * dist4;
        n = 0;
        while (lhs > rhs && int'(r.depth) + n < int'(TOP)) begin
            rhs = rhs << 2;
            n++;
        end
        res.mark_level = (int'(r.depth) + n > int'(TOP)) ? TOP : 8'(int'(r.depth) + n);
        return res;
    endfunction

    // tracks config writes, accepted requests and incoming marks
    always @(posedge i_clk) begin
        fcl_pkg::t_result got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) plane_coef[i] = '0;
            eye[0] = fcl_pkg::EYE_RST; eye[1] = fcl_pkg::EYE_RST; eye[2] = fcl_pkg::EYE_RST;
            scale = fcl_pkg::LOD_SCALE_RST;
            out_levels = fcl_pkg::OUTSIDE_LEVELS_RST;
            depth_limit = fcl_pkg::MAX_DEPTH_RST;
        end else begin
            if (i_cfg_we) begin
                case (fcl_pkg::t_cfg_idx'(i_cfg_idx))
                    fcl_pkg::CFG_EYE_X:          eye[0] = i_cfg_data;
                    fcl_pkg::CFG_EYE_Y:          eye[1] = i_cfg_data;
                    fcl_pkg::CFG_EYE_Z:          eye[2] = i_cfg_data;
                    fcl_pkg::CFG_LOD_SCALE:      scale = i_cfg_data;
                    fcl_pkg::CFG_OUTSIDE_LEVELS: out_levels = i_cfg_data[7:0];
                    fcl_pkg::CFG_MAX_DEPTH:      depth_limit = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (o_valid) begin
                got = o_result;
                if (pending_marks.size() == 0) begin
                    $error("unexpected mark: mark_level %0d is_outside %0d",
                           got.mark_level, got.is_outside);
                    err_count++;
                end else begin
                    want = pending_marks.pop_front();
                    if (got.mark_level !== want.mark_level) begin
                        $error("mark_level: expected %0d, got %0d",
                               want.mark_level, got.mark_level);
                        err_count++;
                    end
                    if (got.is_outside !== want.is_outside) begin
                        $error("is_outside: expected %0d, got %0d",
                               want.is_outside, got.is_outside);
                        err_count++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                if (i_req.command == fcl_pkg::CMD_LOAD) begin
                    if (i_req.coef_index < SLOTS)
                        plane_coef[i_req.coef_index] = i_req.coef_value;
                end else begin
                    pending_marks.push_back(mark_node(i_req));
                end
            end
        end
    end

    task automatic send_request(fcl_pkg::t_request r);
        i_req <= r;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic load_coef(int idx, logic [31:0] value);
        fcl_pkg::t_request r;
        r = '0;
        r.command = fcl_pkg::CMD_LOAD;
        r.coef_index = 5'(idx);
        r.coef_value = value;
        r.box_min_x = $urandom;
        send_request(r);
    endtask

    task automatic classify(logic [31:0] x0, y0, z0, x1, y1, z1, logic [7:0] d);
        fcl_pkg::t_request r;
        r = '0;
        r.command = fcl_pkg::CMD_CLASSIFY;
        r.coef_index = 5'($urandom);
        r.coef_value = $urandom;
        r.box_min_x = x0; r.box_min_y = y0; r.box_min_z = z0;
        r.box_max_x = x1; r.box_max_y = y1; r.box_max_z = z1;
        r.depth = d;
        send_request(r);
    endtask

    task automatic settle();
        i_start <= 1'b0;
        i_cfg_we <= 1'b0;
        while (pending_marks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // leaves the write enable high; settle() lowers it
    task automatic write_reg(fcl_pkg::t_cfg_idx idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // planes that keep most small boxes inside
    task automatic load_open_frustum(bit noisy);
        for (int i = 0; i < SLOTS; i++) begin
            if (noisy && $urandom_range(9) == 0) load_coef(i, $urandom);
            else if (i % 4 == 3) load_coef(i, $urandom_range(32'h4000_0000, 32'h0100_0000));
            else load_coef(i, $signed($urandom_range(131072)) - 65536);
        end
    endtask

    function automatic logic [31:0] rand_coord(int span);
        return (span >= 31) ? $urandom
                            : $signed($urandom_range((1 << (span + 1)) - 1)) - (1 << span);
    endfunction

    task automatic random_classify();
        int span;
        logic [31:0] x0, y0, z0;
        span = ($urandom_range(9) == 0) ? 31 : $urandom_range(24, 4);
        x0 = rand_coord(span); y0 = rand_coord(span); z0 = rand_coord(span);
        if ($urandom_range(9) == 0)
            classify(x0, y0, z0, rand_coord(span), rand_coord(span), rand_coord(span),
                     8'($urandom_range(254)));
        else
            classify(x0, y0, z0, x0 + $urandom_range(1 << span), y0 + $urandom_range(1 << span),
                     z0 + $urandom_range(1 << span),
                     ($urandom_range(3) == 0) ? 8'($urandom_range(254)) : 8'($urandom_range(12)));
    endtask

    task automatic test_directed();
        load_open_frustum(0);
        classify(-65536, -65536, -65536, 65536, 65536, 65536, 0);
        classify(0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 254);
        classify(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 3);
        classify(100, 100, 100, 100, 100, 100, 7);
        classify(65536, 65536, 65536, -65536, -65536, -65536, 1);
        classify(32'h0100_0000, 0, 0, 32'h0200_0000, 65536, 65536, 250);
        classify(32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0, 9);
        load_coef(31, 32'hffff_ffff);
        load_coef(24, 32'h8000_0000);
        load_coef(3, 32'h8000_0000);
        classify(0, 0, 0, 65536, 65536, 65536, 200);
        load_coef(3, 32'h7fff_ffff);
        classify(-65536, 0, 0, 65536, 65536, 65536, 5);
        settle();
    endtask

    task automatic test_config_extremes();
        write_reg(fcl_pkg::CFG_EYE_X, 32'h7fff_ffff);
        write_reg(fcl_pkg::CFG_EYE_Y, 32'h8000_0000);
        write_reg(fcl_pkg::CFG_EYE_Z, 32'h8000_0000);
        write_reg(fcl_pkg::CFG_LOD_SCALE, 32'hffff_ffff);
        write_reg(fcl_pkg::CFG_OUTSIDE_LEVELS, 32'd255);
        write_reg(fcl_pkg::CFG_MAX_DEPTH, 32'd0);
        settle();
        classify(0, 0, 0, 65536, 65536, 65536, 0);
        classify(0, 0, 0, 65536, 65536, 65536, 1);
        classify(32'h8000_0000, 0, 0, 32'h7fff_ffff, 65536, 65536, 0);
        for (int i = 0; i < 20; i++) random_classify();
        settle();
        write_reg(fcl_pkg::CFG_EYE_X, 0);
        write_reg(fcl_pkg::CFG_EYE_Y, 0);
        write_reg(fcl_pkg::CFG_EYE_Z, 0);
        write_reg(fcl_pkg::CFG_LOD_SCALE, 0);
        write_reg(fcl_pkg::CFG_MAX_DEPTH, 32'd254);
        settle();
        classify(-65536, -65536, -65536, 65536, 65536, 65536, 4);
        for (int i = 0; i < 20; i++) random_classify();
        settle();
        write_reg(fcl_pkg::CFG_LOD_SCALE, 1);
        write_reg(fcl_pkg::CFG_OUTSIDE_LEVELS, 0);
        settle();
        classify(-65536, -65536, 65536, 65536, 65536, 131072, 10);
        classify(0, 0, 32'h7fff_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 240);
        for (int i = 0; i < 20; i++) random_classify();
        settle();
    endtask

    task automatic test_random(int count);
        int done;
        write_reg(fcl_pkg::CFG_EYE_X, rand_coord($urandom_range(24, 4)));
        write_reg(fcl_pkg::CFG_EYE_Y, rand_coord($urandom_range(24, 4)));
        write_reg(fcl_pkg::CFG_EYE_Z, rand_coord($urandom_range(24, 4)));
        write_reg(fcl_pkg::CFG_LOD_SCALE, $urandom_range(32'h0004_0000, 32'h0000_0100));
        write_reg(fcl_pkg::CFG_OUTSIDE_LEVELS, $urandom_range(255));
        write_reg(fcl_pkg::CFG_MAX_DEPTH, $urandom_range(254, 100));
        settle();
        done = 0;
        while (done < count) begin
            case ($urandom_range(19))
                0: begin
                    load_open_frustum($urandom_range(1));
                    done += SLOTS;
                end
                1: begin
                    load_coef($urandom_range(31), $urandom);
                    done++;
                end
                default: begin
                    random_classify();
                    done++;
                end
            endcase
        end
        settle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        err_count = 0;
        idle_pct = 8;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random(450);
        idle_pct = 56;
        test_random(450);
        idle_pct = 0;
        test_random(450);
        if (err_count == 0)
            $display("tb_frustum_cull_lod_marker: done, clean");
        else
            $display("tb_frustum_cull_lod_marker: done, errors");
        $finish;
    end
endmodule
